// File: sv/gait_joint_trajectory_generator_defines.svh
// assertion macros for the gait joint trajectory generator
`ifndef GAIT_JOINT_TRAJECTORY_GENERATOR_DEFINES_SVH
`define GAIT_JOINT_TRAJECTORY_GENERATOR_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define GJT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define GJT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/gjt_pkg.sv
// shared types, constants and functions of the gait joint trajectory generator
package gjt_pkg;
	localparam int SineDepthDefault = 256;
	localparam int FracBitsDefault = 8;
	localparam int NumCfg = 8;

	localparam logic [2:0] CfgGaitTrot = 3'd0;
	localparam logic [2:0] CfgSpeed = 3'd1;
	localparam logic [2:0] CfgPhaseInc = 3'd2;
	localparam logic [2:0] CfgHipAmp = 3'd3;
	localparam logic [2:0] CfgKneeAmp = 3'd4;
	localparam logic [2:0] CfgAngleLimit = 3'd5;
	localparam logic [2:0] CfgSlewStep = 3'd6;
	localparam logic [2:0] CfgAccelStep = 3'd7;

	localparam logic [2:0] DirFwd = 3'd0;
	localparam logic [2:0] DirBack = 3'd1;
	localparam logic [2:0] DirTurnL = 3'd2;
	localparam logic [2:0] DirTurnR = 3'd3;
	localparam logic [2:0] DirShiftL = 3'd4;
	localparam logic [2:0] DirShiftR = 3'd5;
	localparam logic [2:0] DirStop = 3'd6;

	localparam logic [1:0] RampIdle = 2'd0;
	localparam logic [1:0] RampFall = 2'd1;
	localparam logic [1:0] RampRise = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAMP,
		ST_FACT,
		ST_PHASE,
		ST_HSPD,
		ST_HAMP,
		ST_KSPD,
		ST_KAMP,
		ST_SINE,
		ST_HIP,
		ST_KNEE,
		ST_LIM_H,
		ST_LIM_K,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       gait_trot;
		logic [15:0] speed;
		logic [13:0] phase_increment;
		logic [14:0] hip_swing;
		logic [14:0] knee_swing;
		logic [14:0] joint_clamp;
		logic [12:0] slew_step;
		logic [11:0] accel_step;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  leg;
		logic signed [15:0] hip_angle;
		logic signed [15:0] knee_angle;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        command;
		logic [2:0]  direction;
	} cmd_t;

	// sin(pi/2*x), x in q15 0..32768, result clipped to 32767
	function automatic logic [14:0] quarter_wave(input logic [15:0] x);
		logic [31:0] x2;
		logic [31:0] t;
		logic [47:0] u;
		logic [47:0] y;
		begin
			x2 = (32'(x) * 32'(x)) >> 15;
			t = 32'd21024 - ((32'd2320 * x2) >> 15);
			u = 48'd51472 - ((48'(x2) * 48'(t)) >> 15);
			y = (48'(x) * u) >> 15;
			quarter_wave = (y > 48'd32767) ? 15'd32767 : y[14:0];
		end
	endfunction
endpackage

// File: sv/gjt_stream_if.sv
// valid/ready channel carrying one payload
interface gjt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/gjt_sine_rom.sv
// sine lookup over a full cycle built from a quarter-wave polynomial table
module gjt_sine_rom #(
	parameter int SINE_TABLE_DEPTH = gjt_pkg::SineDepthDefault
) (
	input  logic              clk,
	input  logic [15:0]       phase,
	output logic signed [15:0] sine
);
	localparam int IdxW = $clog2(SINE_TABLE_DEPTH);
	localparam int QDepth = SINE_TABLE_DEPTH / 4;

	logic [14:0] quarter_tbl [QDepth+1];
	logic [IdxW-1:0] k;
	logic [15:0] pq;
	logic [1:0] quad;
	logic [15:0] x;
	logic [IdxW-3:0] qi;
	logic [IdxW-2:0] sel;
	logic [14:0] mag;

	for (genvar g = 0; g <= QDepth; g++) begin : g_tbl
		assign quarter_tbl[g] = gjt_pkg::quarter_wave(16'((g * 32768) / QDepth));
	end

	always_comb begin
		k = phase[15 -: IdxW];
		pq = 16'({k, {(16 - IdxW){1'b0}}});
		quad = pq[15:14];
		qi = k[IdxW-3:0];
		sel = quad[0] ? (IdxW - 1)'(QDepth) - {1'b0, qi} : {1'b0, qi};
		x = 16'(sel);
		mag = quarter_tbl[x[IdxW-2:0]];
	end

	always_ff @(posedge clk) begin
		sine <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end
endmodule

// File: sv/gjt_datapath.sv
// sequenced datapath: shared multiplier, ramp, phase, targets and limiter
module gjt_datapath #(
	parameter int SINE_TABLE_DEPTH = gjt_pkg::SineDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gjt_pkg::cfg_t   cfg,
	input  gjt_pkg::state_t state,
	input  logic [1:0]      leg_q,
	input  logic            start,
	input  logic            is_dir,
	input  logic [2:0]      dir_in,
	output gjt_pkg::result_t result
);
	logic [15:0] spd;
	logic [15:0] gait_phase_q;
	logic [15:0] ramp_level_q;
	logic        ramp_goal_high_q;
	logic [1:0]  ramp_stage_q;
	logic [2:0]  move_direction_q;
	logic signed [15:0] joint_angle_q [8];
	logic signed [15:0] joint_last_step_q [8];
	logic [15:0] factor_q;
	logic [15:0] amp_spd_q;
	logic [15:0] hamp_q;
	logic [15:0] kamp_q;
	logic signed [16:0] hip_goal_q;
	logic signed [16:0] knee_goal_q;
	logic signed [15:0] new_hip_q;
	logic [15:0] leg_phase;
	logic signed [15:0] sine;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [15:0] rstep;
	logic [16:0] rsum;
	logic [2:0]  dsat;
	logic [15:0] off;
	logic [15:0] smag;
	logic [15:0] pos;
	logic signed [17:0] hp;
	logic signed [17:0] kn;
	logic signed [17:0] hg;
	logic signed [17:0] kg;
	logic        left;
	logic [2:0]  jidx;
	logic signed [16:0] goal;
	logic signed [17:0] lim;
	logic signed [17:0] diff;
	logic signed [17:0] sl;
	logic signed [17:0] ac;
	logic signed [17:0] prv;
	logic signed [17:0] stp;
	logic signed [17:0] nxt;
	logic signed [15:0] nsat;
	logic        near;

	assign spd = (cfg.speed > 16'd32768) ? 16'd32768 : cfg.speed;

	always_comb begin
		unique case (cfg.gait_trot)
			1'b1: off = (leg_q == 2'd1 || leg_q == 2'd2) ? 16'd32768 : 16'd0;
			default: off = {leg_q, 14'd0};
		endcase
		leg_phase = gait_phase_q + off;
	end

	gjt_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
		.clk(clk), .phase(leg_phase), .sine(sine)
	);

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		smag = sine[15] ? 16'(-sine) : 16'(sine);
		pos = sine[15] ? 16'd0 : 16'(sine);
		unique case (state)
			gjt_pkg::ST_RAMP: begin mul_a = 32'(spd); mul_b = 32'd3277; end
			gjt_pkg::ST_FACT: begin mul_a = 32'(spd); mul_b = 32'd26214; end
			gjt_pkg::ST_PHASE: begin
				mul_a = 32'(cfg.phase_increment);
				mul_b = 32'(factor_q);
			end
			gjt_pkg::ST_HSPD: begin mul_a = 32'(cfg.hip_swing); mul_b = 32'(spd); end
			gjt_pkg::ST_HAMP: begin mul_a = 32'(amp_spd_q); mul_b = 32'(ramp_level_q); end
			gjt_pkg::ST_KSPD: begin mul_a = 32'(cfg.knee_swing); mul_b = 32'(spd); end
			gjt_pkg::ST_KAMP: begin mul_a = 32'(amp_spd_q); mul_b = 32'(ramp_level_q); end
			gjt_pkg::ST_HIP: begin mul_a = 32'(smag); mul_b = 32'(hamp_q); end
			gjt_pkg::ST_KNEE: begin mul_a = 32'(pos); mul_b = 32'(kamp_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	always_comb begin
		rstep = 16'd1966 + 16'(mul_p >> 15);
		rsum = 17'(ramp_level_q) + 17'(rstep);
		dsat = (dir_in == 3'd7) ? gjt_pkg::DirStop : dir_in;
		hp = sine[15] ? -18'(mul_p[30:15]) : 18'(mul_p[30:15]);
		kn = (move_direction_q == gjt_pkg::DirShiftL || move_direction_q == gjt_pkg::DirShiftR)
			? -18'(mul_p[31:16]) : -18'(mul_p[30:15]);
		left = !leg_q[0];
		unique case (move_direction_q)
			gjt_pkg::DirFwd, gjt_pkg::DirShiftL: hg = hp;
			gjt_pkg::DirBack, gjt_pkg::DirShiftR: hg = -hp;
			gjt_pkg::DirTurnL: hg = left ? hp : -hp;
			gjt_pkg::DirTurnR: hg = left ? -hp : hp;
			default: hg = '0;
		endcase
		kg = (move_direction_q == gjt_pkg::DirStop || move_direction_q == 3'd7) ? 18'sd0 : kn;
	end

	// limiter for one joint per cycle
	always_comb begin
		jidx = {leg_q, state == gjt_pkg::ST_LIM_K};
		goal = (state == gjt_pkg::ST_LIM_K) ? knee_goal_q : hip_goal_q;
		lim = 18'(cfg.joint_clamp);
		sl = 18'(cfg.slew_step);
		ac = 18'(cfg.accel_step);
		prv = 18'(joint_last_step_q[jidx]);
		diff = 18'(goal) - 18'(joint_angle_q[jidx]);
		near = (diff <= sl) && (diff >= -sl);
		stp = (diff > 0) ? sl : -sl;
		if (stp - prv > ac) begin
			stp = prv + ac;
		end else if (stp - prv < -ac) begin
			stp = prv - ac;
		end
		nxt = 18'(joint_angle_q[jidx]) + stp;
		if (nxt > 18'sd32767) begin
			nsat = 16'sh7fff;
		end else if (nxt < -18'sd32768) begin
			nsat = 16'sh8000;
		end else begin
			nsat = nxt[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gait_phase_q <= '0;
			ramp_level_q <= '0;
			ramp_goal_high_q <= 1'b0;
			ramp_stage_q <= gjt_pkg::RampIdle;
			move_direction_q <= gjt_pkg::DirStop;
			for (int i = 0; i < 8; i++) begin
				joint_angle_q[i] <= '0;
				joint_last_step_q[i] <= '0;
			end
		end else begin
			if (start && is_dir) begin
				if (!(dsat == move_direction_q && dsat != gjt_pkg::DirStop)) begin
					move_direction_q <= dsat;
					if (dsat == gjt_pkg::DirStop) begin
						ramp_goal_high_q <= 1'b0;
						ramp_stage_q <= gjt_pkg::RampIdle;
					end else if (ramp_level_q >= 16'd33) begin
						ramp_stage_q <= gjt_pkg::RampFall;
						ramp_goal_high_q <= 1'b0;
					end else begin
						ramp_stage_q <= gjt_pkg::RampRise;
						ramp_goal_high_q <= 1'b1;
					end
				end
			end
			if (state == gjt_pkg::ST_RAMP) begin
				logic [15:0] lvl;
				lvl = ramp_level_q;
				if (ramp_goal_high_q) begin
					lvl = (rsum > 17'd32768) ? 16'd32768 : rsum[15:0];
				end else begin
					lvl = (ramp_level_q > rstep) ? ramp_level_q - rstep : 16'd0;
				end
				ramp_level_q <= lvl;
				if (ramp_stage_q == gjt_pkg::RampFall && lvl <= 16'd32) begin
					ramp_stage_q <= gjt_pkg::RampRise;
					ramp_goal_high_q <= 1'b1;
				end else if (ramp_stage_q == gjt_pkg::RampRise && lvl >= 16'd32736) begin
					ramp_stage_q <= gjt_pkg::RampIdle;
				end
			end
			if (state == gjt_pkg::ST_PHASE) begin
				gait_phase_q <= gait_phase_q + mul_p[30:15];
			end
			if (state == gjt_pkg::ST_LIM_H || state == gjt_pkg::ST_LIM_K) begin
				if (near) begin
					joint_last_step_q[jidx] <= '0;
					joint_angle_q[jidx] <= goal[15:0];
				end else begin
					joint_last_step_q[jidx] <= stp[15:0];
					joint_angle_q[jidx] <= nsat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state == gjt_pkg::ST_FACT) begin
			factor_q <= 16'd13107 + mul_p[30:15];
		end
		if (state == gjt_pkg::ST_HSPD || state == gjt_pkg::ST_KSPD) begin
			amp_spd_q <= mul_p[30:15];
		end
		if (state == gjt_pkg::ST_HAMP) begin
			hamp_q <= mul_p[30:15];
		end
		if (state == gjt_pkg::ST_KAMP) begin
			kamp_q <= mul_p[30:15];
		end
		if (state == gjt_pkg::ST_HIP) begin
			hip_goal_q <= 17'((hg > lim) ? lim : ((hg < -lim) ? -lim : hg));
		end
		if (state == gjt_pkg::ST_KNEE) begin
			knee_goal_q <= 17'((kg > lim) ? lim : ((kg < -lim) ? -lim : kg));
		end
		if (state == gjt_pkg::ST_LIM_H) begin
			new_hip_q <= near ? goal[15:0] : nsat;
		end
		if (state == gjt_pkg::ST_LIM_K) begin
			result.leg <= leg_q;
			result.hip_angle <= new_hip_q;
			result.knee_angle <= near ? goal[15:0] : nsat;
			result.last <= (leg_q == 2'd3);
		end
	end
endmodule

// File: sv/gjt_sequencer.sv
// sequencer stepping the shared datapath through a transaction
module gjt_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_command,
	input  logic            out_ready,
	output logic            in_ready,
	output logic            out_valid,
	output logic            start,
	output gjt_pkg::state_t state,
	output logic [1:0]      leg_q
);
	`include "gait_joint_trajectory_generator_defines.svh"

	gjt_pkg::state_t state_q;
	gjt_pkg::state_t state_d;

	assign state = state_q;
	assign start = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gjt_pkg::ST_IDLE: if (start && !in_command) state_d = gjt_pkg::ST_RAMP;
			gjt_pkg::ST_RAMP: state_d = gjt_pkg::ST_FACT;
			gjt_pkg::ST_FACT: state_d = gjt_pkg::ST_PHASE;
			gjt_pkg::ST_PHASE: state_d = gjt_pkg::ST_HSPD;
			gjt_pkg::ST_HSPD: state_d = gjt_pkg::ST_HAMP;
			gjt_pkg::ST_HAMP: state_d = gjt_pkg::ST_KSPD;
			gjt_pkg::ST_KSPD: state_d = gjt_pkg::ST_KAMP;
			gjt_pkg::ST_KAMP: state_d = gjt_pkg::ST_SINE;
			gjt_pkg::ST_SINE: state_d = gjt_pkg::ST_HIP;
			gjt_pkg::ST_HIP: state_d = gjt_pkg::ST_KNEE;
			gjt_pkg::ST_KNEE: state_d = gjt_pkg::ST_LIM_H;
			gjt_pkg::ST_LIM_H: state_d = gjt_pkg::ST_LIM_K;
			gjt_pkg::ST_LIM_K: state_d = gjt_pkg::ST_OUT;
			gjt_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = (leg_q == 2'd3) ? gjt_pkg::ST_IDLE : gjt_pkg::ST_SINE;
				end
			end
			default: state_d = gjt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == gjt_pkg::ST_IDLE);
		out_valid = (state_q == gjt_pkg::ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gjt_pkg::ST_IDLE;
			leg_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == gjt_pkg::ST_IDLE) begin
				leg_q <= '0;
			end else if (state_q == gjt_pkg::ST_OUT && out_ready) begin
				leg_q <= leg_q + 2'd1;
			end
		end
	end

	`GJT_ASSERT_IMP(a_ready_excl, clk, arst_n, in_ready, !out_valid, "ready while result pending")
	`GJT_ASSERT_NEXT(a_tick_start, clk, arst_n, start && !in_command, state_q == gjt_pkg::ST_RAMP, "tick did not start")
	`GJT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(leg_q), "result dropped")
	`GJT_ASSERT_IMP(a_leg_zero, clk, arst_n, state_q == gjt_pkg::ST_RAMP, leg_q == 2'd0, "leg count not cleared")
endmodule

// File: sv/gait_joint_trajectory_generator.sv
// top level of the gait joint trajectory generator
// channel   dir  payload
// in_ch     in   command, direction
// out_ch    out  leg, hip_angle, knee_angle, last
// cfg       in   cfg_we, cfg_index, cfg_data
// a direction is taken in idle; a tick runs ramp to amplitude, then sine to output per leg
// the single shared multiplier sets the sequence length, at most one product per step
// reset clears all joint, ramp and phase state; a stalled result holds the sequencer
module gait_joint_trajectory_generator #(
	parameter int SINE_TABLE_DEPTH = gjt_pkg::SineDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	gjt_stream_if.sink   in_ch,
	gjt_stream_if.source out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	gjt_pkg::cfg_t    cfg_q;
	gjt_pkg::state_t  state;
	gjt_pkg::cmd_t    cmd;
	gjt_pkg::result_t result;
	logic [1:0]       leg_q;
	logic             start;

	assign cmd = in_ch.data;
	assign out_ch.data = result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gait_trot <= 1'b1;
			cfg_q.speed <= 16'd16384;
			cfg_q.phase_increment <= 14'd1311;
			cfg_q.hip_swing <= 15'd6400;
			cfg_q.knee_swing <= 15'd6400;
			cfg_q.joint_clamp <= 15'd15360;
			cfg_q.slew_step <= 13'd1280;
			cfg_q.accel_step <= 12'd512;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gjt_pkg::CfgGaitTrot: cfg_q.gait_trot <= cfg_data[0];
				gjt_pkg::CfgSpeed: cfg_q.speed <= cfg_data;
				gjt_pkg::CfgPhaseInc: cfg_q.phase_increment <= cfg_data[13:0];
				gjt_pkg::CfgHipAmp: cfg_q.hip_swing <= cfg_data[14:0];
				gjt_pkg::CfgKneeAmp: cfg_q.knee_swing <= cfg_data[14:0];
				gjt_pkg::CfgAngleLimit: cfg_q.joint_clamp <= cfg_data[14:0];
				gjt_pkg::CfgSlewStep: cfg_q.slew_step <= cfg_data[12:0];
				gjt_pkg::CfgAccelStep: cfg_q.accel_step <= cfg_data[11:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	gjt_sequencer u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_command(cmd.command),
		.out_ready(out_ch.ready), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .start(start), .state(state), .leg_q(leg_q)
	);

	gjt_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .state(state), .leg_q(leg_q),
		.start(start), .is_dir(cmd.command), .dir_in(cmd.direction), .result(result)
	);
endmodule

// File: test/testbench.sv
// self-checking testbench for the gait joint trajectory generator
module testbench;
	localparam logic CmdTick = 1'b0;
	localparam logic CmdDir = 1'b1;
	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 40;

	class gait_scoreboard;
		bit trot;
		int unsigned spd_reg, pinc, hip_swing, knee_swing, lim, slew, accel;
		int unsigned phase, ramp, goal_high, stage;
		logic [2:0] heading;
		int angle[8];
		int last_step[8];
		gjt_pkg::result_t leg_q[$];
		int errors;

		function new();
			trot = 1;
			spd_reg = 16384;
			pinc = 1311;
			hip_swing = 6400;
			knee_swing = 6400;
			lim = 15360;
			slew = 1280;
			accel = 512;
			phase = 0;
			ramp = 0;
			goal_high = 0;
			stage = gjt_pkg::RampIdle;
			heading = gjt_pkg::DirStop;
			foreach (angle[i]) begin
				angle[i] = 0;
				last_step[i] = 0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				gjt_pkg::CfgGaitTrot: trot = v[0];
				gjt_pkg::CfgSpeed: spd_reg = v;
				gjt_pkg::CfgPhaseInc: pinc = v[13:0];
				gjt_pkg::CfgHipAmp: hip_swing = v[14:0];
				gjt_pkg::CfgKneeAmp: knee_swing = v[14:0];
				gjt_pkg::CfgAngleLimit: lim = v[14:0];
				gjt_pkg::CfgSlewStep: slew = v[12:0];
				gjt_pkg::CfgAccelStep: accel = v[11:0];
				default: ;
			endcase
		endfunction

		function int sine_at(int unsigned ph);
			longint unsigned pq, quad, x, x2, t, u, y;
			int v;
			pq = ((ph & 16'hFFFF) >> 8) << 8;
			quad = pq >> 14;
			x = (pq & 16'h3FFF) << 1;
			if (quad & 1) x = 32768 - x;
			x2 = (x * x) >> 15;
			t = 21024 - ((2320 * x2) >> 15);
			u = 51472 - ((x2 * t) >> 15);
			y = (x * u) >> 15;
			v = (y > 32767) ? 32767 : int'(y);
			return (quad & 2) ? -v : v;
		endfunction

		function int scaled(int v, int unsigned m, int sh);
			longint r;
			r = ((v < 0 ? -longint'(v) : longint'(v)) * longint'(m)) >>> sh;
			return int'(v < 0 ? -r : r);
		endfunction

		function int clamp(int v);
			int l;
			l = lim;
			return v > l ? l : (v < -l ? -l : v);
		endfunction

		function int slew_joint(int j, int target);
			int diff, sl, ac, prev, stp, r;
			diff = target - angle[j];
			sl = slew;
			ac = accel;
			prev = last_step[j];
			if (diff <= sl && diff >= -sl) begin
				last_step[j] = 0;
				return target;
			end
			stp = diff > 0 ? sl : -sl;
			if (stp - prev > ac) stp = prev + ac;
			else if (stp - prev < -ac) stp = prev - ac;
			last_step[j] = stp;
			r = angle[j] + stp;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r;
		endfunction

		function void note_transaction(gjt_pkg::cmd_t c);
			int unsigned spd, stp, goal, hamp, kamp, ph, offs;
			int sv, pos, hp, kf, kh, hg, kg;
			logic [2:0] d;
			bit left;
			gjt_pkg::result_t r;
			if (c.command == CmdDir) begin
				d = (c.direction > gjt_pkg::DirStop) ? gjt_pkg::DirStop : c.direction;
				if (d == heading && d != gjt_pkg::DirStop) return;
				heading = d;
				if (d == gjt_pkg::DirStop) begin
					goal_high = 0;
					stage = gjt_pkg::RampIdle;
				end else if (ramp >= 33) begin
					stage = gjt_pkg::RampFall;
					goal_high = 0;
				end else begin
					stage = gjt_pkg::RampRise;
					goal_high = 1;
				end
				return;
			end
			spd = spd_reg > 32768 ? 32768 : spd_reg;
			stp = 1966 + ((spd * 3277) >> 15);
			goal = goal_high ? 32768 : 0;
			if (ramp < goal) begin
				ramp += stp;
				if (ramp > goal) ramp = goal;
			end else if (ramp > goal) begin
				ramp = (ramp - goal > stp) ? ramp - stp : goal;
			end
			if (stage == gjt_pkg::RampFall && ramp <= 32) begin
				stage = gjt_pkg::RampRise;
				goal_high = 1;
			end else if (stage == gjt_pkg::RampRise && ramp >= 32736) begin
				stage = gjt_pkg::RampIdle;
			end
			phase = (phase + ((pinc * (13107 + ((spd * 26214) >> 15))) >> 15)) & 16'hFFFF;
			hamp = (((hip_swing * spd) >> 15) * ramp) >> 15;
			kamp = (((knee_swing * spd) >> 15) * ramp) >> 15;
			for (int lg = 0; lg < 4; lg++) begin
				if (trot) offs = (lg == 1 || lg == 2) ? 32768 : 0;
				else offs = lg * 16384;
				ph = (phase + offs) & 16'hFFFF;
				sv = sine_at(ph);
				pos = sv > 0 ? sv : 0;
				hp = scaled(sv, hamp, 15);
				kf = -scaled(pos, kamp, 15);
				kh = -scaled(pos, kamp, 16);
				left = (lg == 0 || lg == 2);
				case (heading)
					gjt_pkg::DirFwd: begin hg = hp; kg = kf; end
					gjt_pkg::DirBack: begin hg = -hp; kg = kf; end
					gjt_pkg::DirTurnL: begin hg = left ? hp : -hp; kg = kf; end
					gjt_pkg::DirTurnR: begin hg = left ? -hp : hp; kg = kf; end
					gjt_pkg::DirShiftL: begin hg = hp; kg = kh; end
					gjt_pkg::DirShiftR: begin hg = -hp; kg = kh; end
					default: begin hg = 0; kg = 0; end
				endcase
				angle[lg * 2] = slew_joint(lg * 2, clamp(hg));
				angle[lg * 2 + 1] = slew_joint(lg * 2 + 1, clamp(kg));
				r.leg = 2'(lg);
				r.hip_angle = angle[lg * 2][15:0];
				r.knee_angle = angle[lg * 2 + 1][15:0];
				r.last = (lg == 3);
				leg_q.push_back(r);
			end
		endfunction

		function void check_result(gjt_pkg::result_t got);
			gjt_pkg::result_t exp_r;
			if (leg_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result leg %0d", got.leg);
				return;
			end
			exp_r = leg_q.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp leg %0d hip %0d knee %0d last %0d, got leg %0d hip %0d knee %0d last %0d",
						exp_r.leg, exp_r.hip_angle, exp_r.knee_angle, exp_r.last,
						got.leg, got.hip_angle, got.knee_angle, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	int tx_idle, rx_idle, rx_hold, cycles;
	gait_scoreboard sb;

	gjt_stream_if #(.payload_t(gjt_pkg::cmd_t)) in_ch ();
	gjt_stream_if #(.payload_t(gjt_pkg::result_t)) out_ch ();

	gait_joint_trajectory_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("gait_joint_trajectory_generator verification failed");
			$finish;
		end
	end

	// receiver with random stalls and long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_transaction(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
	end

	task automatic send(logic c, logic [2:0] d);
		in_ch.valid <= 1'b1;
		in_ch.data <= '{command: c, direction: d};
		do @(posedge clk); while (!in_ch.ready);
		if ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.leg_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic program_all(int s);
		case (s)
			0: begin
				write_reg(gjt_pkg::CfgGaitTrot, 0); write_reg(gjt_pkg::CfgSpeed, 32768);
				write_reg(gjt_pkg::CfgPhaseInc, 13107); write_reg(gjt_pkg::CfgHipAmp, 23040);
				write_reg(gjt_pkg::CfgKneeAmp, 23040); write_reg(gjt_pkg::CfgAngleLimit, 2560);
				write_reg(gjt_pkg::CfgSlewStep, 5120); write_reg(gjt_pkg::CfgAccelStep, 2560);
			end
			1: begin
				write_reg(gjt_pkg::CfgGaitTrot, 1); write_reg(gjt_pkg::CfgSpeed, 0);
				write_reg(gjt_pkg::CfgPhaseInc, 66); write_reg(gjt_pkg::CfgHipAmp, 0);
				write_reg(gjt_pkg::CfgKneeAmp, 0); write_reg(gjt_pkg::CfgAngleLimit, 23040);
				write_reg(gjt_pkg::CfgSlewStep, 128); write_reg(gjt_pkg::CfgAccelStep, 26);
			end
			2: begin
				write_reg(gjt_pkg::CfgGaitTrot, 0); write_reg(gjt_pkg::CfgSpeed, 16'hFFFF);
				write_reg(gjt_pkg::CfgPhaseInc, 16'h3FFF); write_reg(gjt_pkg::CfgHipAmp, 16'h7FFF);
				write_reg(gjt_pkg::CfgKneeAmp, 16'h7FFF);
				write_reg(gjt_pkg::CfgAngleLimit, 23040);
				write_reg(gjt_pkg::CfgSlewStep, 16'h1FFF);
				write_reg(gjt_pkg::CfgAccelStep, 16'hFFF);
			end
			default: begin
				write_reg(gjt_pkg::CfgGaitTrot, $urandom_range(1));
				write_reg(gjt_pkg::CfgSpeed, $urandom_range(32768));
				write_reg(gjt_pkg::CfgPhaseInc, $urandom_range(66, 13107));
				write_reg(gjt_pkg::CfgHipAmp, $urandom_range(23040));
				write_reg(gjt_pkg::CfgKneeAmp, $urandom_range(23040));
				write_reg(gjt_pkg::CfgAngleLimit, $urandom_range(2560, 23040));
				write_reg(gjt_pkg::CfgSlewStep, $urandom_range(128, 5120));
				write_reg(gjt_pkg::CfgAccelStep, $urandom_range(26, 2560));
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		cycles = 0;
		rx_hold = 0;
		tx_idle = 35;
		rx_idle = 71;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every heading, repeats, code seven, stop
		send(CmdTick, 3'd7);
		send(CmdDir, gjt_pkg::DirFwd);
		repeat (4) send(CmdTick, 3'd0);
		send(CmdDir, gjt_pkg::DirFwd);
		send(CmdTick, 3'd5);
		for (int d = gjt_pkg::DirBack; d <= gjt_pkg::DirShiftR; d++) begin
			send(CmdDir, d);
			send(CmdTick, 3'd2);
			send(CmdTick, 3'd0);
		end
		send(CmdDir, 3'd7);
		send(CmdTick, 3'd0);
		send(CmdDir, gjt_pkg::DirStop);
		send(CmdDir, gjt_pkg::DirStop);
		send(CmdTick, 3'd0);
		drain();

		for (int s = 0; s < 6; s++) begin
			if (s == 2) begin tx_idle = 71; rx_idle = 35; end
			if (s == 4) begin tx_idle = 0; rx_idle = 0; end
			program_all(s);
			if (s == 1) rx_hold = 400;
			for (int n = 0; n < 56; n++) begin
				if (s == 3 && n == 28) begin
					in_ch.valid <= 1'b0;
					@(posedge clk);
					while (sb.leg_q.size() != 0) @(posedge clk);
				end
				if ($urandom_range(99) < 20)
					send(CmdDir, $urandom_range(7));
				else
					send(CmdTick, $urandom_range(7));
			end
			drain();
		end

		if (sb.errors == 0 && sb.leg_q.size() == 0) begin
			$display("gait_joint_trajectory_generator verification clean");
		end else begin
			$display("gait_joint_trajectory_generator verification failed");
		end
		$finish;
	end
endmodule
